// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/hagt_pkg.sv -----
// Types and constants of the arc gap end trimmer.
// No dependencies.
package hagt_pkg;

   localparam int ARC_W         = 22;
   localparam int GAP_W         = 21;
   localparam int HIT_NUM_W     = 6;
   localparam int SMALL_SEGMENT = 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam logic [GAP_W-1:0] RESET_GAP = 21'd2560;
   localparam logic REG_MAX_ARC_GAP = 1'b0;

   typedef struct packed {
      logic new_seg;
      logic final_hit;
      logic skip;
      logic dropped;
   } hagt_entry_type;

   typedef struct packed {
      logic           valid;
      hagt_entry_type entry;
   } hagt_push_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_HI_RD,
      ST_HI_CHK,
      ST_LO_RD,
      ST_LO_CHK,
      ST_EMIT
   } hagt_state_type;

endpackage

// ----- rtl/core/hagt_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
module hagt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/hagt_front.sv -----
// Front end: accepts hits, detects segment starts, filters hits beyond capacity.
// Depends on hagt_pkg.
module hagt_front #(
   parameter int MAX_HITS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [21:0]           arc_length,
   input  logic                         final_hit,
   input  logic [20:0]                  max_arc_gap,
   output hagt_pkg::hagt_push_type      push
);
   import hagt_pkg::*;

   localparam int CNT_W = $clog2(MAX_HITS + 1);

   logic [ARC_W-1:0] prev_arc_ff, prev_arc_in;
   logic             have_prev_ff, have_prev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;

   logic [ARC_W:0]   diff;
   logic [ARC_W:0]   mag;
   logic             full;
   logic             new_seg;

   always_comb begin
      diff    = {arc_length[ARC_W-1], arc_length} - {prev_arc_ff[ARC_W-1], prev_arc_ff};
      mag     = diff[ARC_W] ? (~diff + {{ARC_W{1'b0}}, 1'b1}) : diff;
      new_seg = !have_prev_ff || (mag > {2'b00, max_arc_gap});
      full    = (count_ff == CNT_W'(MAX_HITS));

      prev_arc_in  = prev_arc_ff;
      have_prev_in = have_prev_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;

      push.valid            = 1'b0;
      push.entry.new_seg    = new_seg;
      push.entry.final_hit  = final_hit;
      push.entry.skip       = full;
      push.entry.dropped    = overflow_ff || full;

      if (accept) begin
         push.valid = !full || final_hit;
         if (final_hit) begin
            prev_arc_in  = '0;
            have_prev_in = 1'b0;
            count_in     = '0;
            overflow_in  = 1'b0;
         end else if (full) begin
            overflow_in = 1'b1;
         end else begin
            prev_arc_in  = arc_length;
            have_prev_in = 1'b1;
            count_in     = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_arc_ff  <= '0;
         have_prev_ff <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
      end else begin
         prev_arc_ff  <= prev_arc_in;
         have_prev_ff <= have_prev_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
      end
   end

endmodule

// ----- rtl/core/hagt_queue.sv -----
// Short FIFO of classified hits between front and back end.
// Depends on hagt_pkg.
module hagt_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  hagt_pkg::hagt_push_type  push,
   input  logic                     pop,
   output logic                     full,
   output logic                     head_valid,
   output hagt_pkg::hagt_entry_type head
);
   import hagt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hagt_entry_type   entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      do_pop     = pop && (count_ff != '0);
      wr_ptr_in  = push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + CNT_W'(push.valid) - CNT_W'(do_pop);
      full       = (count_ff == CNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head       = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/hagt_back.sv -----
// Back end: builds segment tables, walks the end segments, streams remove flags.
// Depends on hagt_pkg and hagt_ram.
module hagt_back #(
   parameter int MAX_HITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  hagt_pkg::hagt_entry_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic [5:0]               rsp_hit_number,
   output logic                     rsp_remove_hit,
   output logic                     rsp_hits_dropped,
   output logic                     rsp_last_result
);
   import hagt_pkg::*;

   localparam int CNT_W = $clog2(MAX_HITS + 1);
   localparam int IDX_W = $clog2(MAX_HITS);

   hagt_state_type   state_ff, state_in;
   logic [CNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   logic [CNT_W-1:0] cur_size_ff, cur_size_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic             multi_ff, multi_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0] s1_k_ff, s1_k_in;
   logic             s1_last_ff, s1_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [5:0]       rsp_num_ff, rsp_num_in;
   logic             rsp_remove_ff, rsp_remove_in;
   logic             rsp_dropped_ff, rsp_dropped_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             seg_wr_en;
   logic [IDX_W-1:0] seg_wr_addr, seg_rd_addr, seg_wr_data, seg_rd_data;
   logic             size_wr_en;
   logic [IDX_W-1:0] size_wr_addr, size_rd_addr;
   logic [CNT_W-1:0] size_wr_data, size_rd_data;

   logic [CNT_W-1:0] seg_sel;
   logic [CNT_W-1:0] size_new;
   logic [CNT_W-1:0] seg_next;

   hagt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_HITS)) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_wr_en),
      .wr_addr (seg_wr_addr),
      .wr_data (seg_wr_data),
      .rd_addr (seg_rd_addr),
      .rd_data (seg_rd_data)
   );

   hagt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_HITS)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_wr_en),
      .wr_addr (size_wr_addr),
      .wr_data (size_wr_data),
      .rd_addr (size_rd_addr),
      .rd_data (size_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      hit_cnt_in  = hit_cnt_ff;
      seg_cnt_in  = seg_cnt_ff;
      cur_size_in = cur_size_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      multi_in    = multi_ff;
      dropped_in  = dropped_ff;
      k_in        = k_ff;
      s1_valid_in = 1'b0;
      s1_k_in     = s1_k_ff;
      s1_last_in  = s1_last_ff;
      pop         = 1'b0;

      seg_sel  = head.new_seg ? seg_cnt_ff : seg_cnt_ff - CNT_W'(1);
      size_new = head.new_seg ? CNT_W'(1) : cur_size_ff + CNT_W'(1);
      seg_next = seg_cnt_ff;

      seg_wr_en    = 1'b0;
      seg_wr_addr  = hit_cnt_ff[IDX_W-1:0];
      seg_wr_data  = seg_sel[IDX_W-1:0];
      seg_rd_addr  = k_ff;
      size_wr_en   = 1'b0;
      size_wr_addr = seg_sel[IDX_W-1:0];
      size_wr_data = size_new;
      size_rd_addr = lo_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (head_valid) begin
               pop = 1'b1;
               if (!head.skip) begin
                  seg_wr_en   = 1'b1;
                  size_wr_en  = 1'b1;
                  hit_cnt_in  = hit_cnt_ff + CNT_W'(1);
                  cur_size_in = size_new;
                  seg_next    = seg_cnt_ff + CNT_W'(head.new_seg);
                  seg_cnt_in  = seg_next;
               end
               if (head.final_hit) begin
                  dropped_in = head.dropped;
                  lo_in      = '0;
                  hi_in      = seg_next;
                  multi_in   = (seg_next > CNT_W'(1));
                  k_in       = '0;
                  state_in   = (seg_next > CNT_W'(1)) ? ST_HI_RD : ST_EMIT;
               end
            end
         end
         ST_HI_RD: begin
            size_rd_addr = IDX_W'(hi_ff - CNT_W'(1));
            state_in     = (hi_ff > lo_ff) ? ST_HI_CHK : ST_LO_RD;
         end
         ST_HI_CHK: begin
            if (size_rd_data <= CNT_W'(SMALL_SEGMENT)) begin
               hi_in    = hi_ff - CNT_W'(1);
               state_in = ST_HI_RD;
            end else begin
               state_in = ST_LO_RD;
            end
         end
         ST_LO_RD: begin
            state_in = (lo_ff < hi_ff) ? ST_LO_CHK : ST_EMIT;
         end
         ST_LO_CHK: begin
            if (size_rd_data <= CNT_W'(SMALL_SEGMENT)) begin
               lo_in    = lo_ff + CNT_W'(1);
               state_in = ST_LO_RD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            s1_valid_in = 1'b1;
            s1_k_in     = k_ff;
            s1_last_in  = (CNT_W'(k_ff) + CNT_W'(1) == hit_cnt_ff);
            k_in        = k_ff + IDX_W'(1);
            if (s1_last_in) begin
               hit_cnt_in  = '0;
               seg_cnt_in  = '0;
               cur_size_in = '0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      rsp_valid_in   = s1_valid_ff;
      rsp_num_in     = HIT_NUM_W'(s1_k_ff);
      rsp_remove_in  = multi_ff && ((CNT_W'(seg_rd_data) < lo_ff) ||
                                    (CNT_W'(seg_rd_data) >= hi_ff));
      rsp_dropped_in = dropped_ff;
      rsp_last_in    = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         hit_cnt_ff   <= '0;
         seg_cnt_ff   <= '0;
         cur_size_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_cnt_ff   <= hit_cnt_in;
         seg_cnt_ff   <= seg_cnt_in;
         cur_size_ff  <= cur_size_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      multi_ff       <= multi_in;
      dropped_ff     <= dropped_in;
      k_ff           <= k_in;
      s1_k_ff        <= s1_k_in;
      s1_last_ff     <= s1_last_in;
      rsp_num_ff     <= rsp_num_in;
      rsp_remove_ff  <= rsp_remove_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit_number   = rsp_num_ff;
   assign rsp_remove_hit   = rsp_remove_ff;
   assign rsp_hits_dropped = rsp_dropped_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

// ----- rtl/core/hit_arc_gap_end_trimmer.sv -----
// Top level: CSR port, front end, hit queue and back end of the arc gap end trimmer.
// With several segments the back end walks the end segments after the final hit
// (ST_HI_RD/ST_HI_CHK from the top, ST_LO_RD/ST_LO_CHK from the bottom), then emits.
// Throughput: hits load one per cycle unless the queue is full; results stream one per
// cycle; the 4-entry queue takes hits while the back end walks and emits a track.
// Sync active-high reset clears track state, sets max_arc_gap to 2560; no result stall.
`include "assert_macros.svh"
module hit_arc_gap_end_trimmer #(
   parameter int MAX_HITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [21:0] req_arc_length,
   input  logic               req_final_hit,
   output logic               rsp_valid,
   output logic [5:0]         rsp_hit_number,
   output logic               rsp_remove_hit,
   output logic               rsp_hits_dropped,
   output logic               rsp_last_result,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import hagt_pkg::*;

   logic [GAP_W-1:0] gap_ff, gap_in;
   logic             accept;
   logic             q_full;
   logic             q_pop;
   logic             q_valid;
   hagt_push_type    push;
   hagt_entry_type   head;

   always_comb begin
      pready = 1'b1;
      gap_in = gap_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_MAX_ARC_GAP)) begin
         gap_in = pwdata[GAP_W-1:0];
      end
      prdata = (paddr[2] == REG_MAX_ARC_GAP) ? {{(32-GAP_W){1'b0}}, gap_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= RESET_GAP;
      end else begin
         gap_ff <= gap_in;
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   hagt_front #(.MAX_HITS(MAX_HITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .arc_length  (req_arc_length),
      .final_hit   (req_final_hit),
      .max_arc_gap (gap_ff),
      .push        (push)
   );

   hagt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (head)
   );

   hagt_back #(.MAX_HITS(MAX_HITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (q_valid),
      .head             (head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_hit_number   (rsp_hit_number),
      .rsp_remove_hit   (rsp_remove_hit),
      .rsp_hits_dropped (rsp_hits_dropped),
      .rsp_last_result  (rsp_last_result)
   );

   `ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset, !rsp_valid)
   `ASSERT_NEXT(a_rsp_numbers_run, clock, reset, rsp_valid && !rsp_last_result, rsp_valid && (rsp_hit_number == $past(rsp_hit_number) + 6'd1))
   `ASSERT_NEXT(a_rsp_first_is_zero, clock, reset, rsp_valid && rsp_last_result, !rsp_valid || (rsp_hit_number == 6'd0))

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for hit_arc_gap_end_trimmer: a directed table of tracks, then random
// tracks built from segments, each result checked against a table value or a behavioral trim predictor.
// Depends on hagt_pkg and the hit_arc_gap_end_trimmer RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hagt_pkg::*;

   localparam int HIT_CAP     = 64;
   localparam int ARC_MIN     = -2097152;
   localparam int ARC_MAX     = 2097151;
   localparam int SETTLE      = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] GAP_ADDR = {REG_MAX_ARC_GAP, 2'b00};
   localparam logic [GAP_W-1:0] GAP_TOP = {GAP_W{1'b1}};

   typedef struct packed {
      logic [HIT_NUM_W-1:0] hit_number;
      logic                 remove_hit;
      logic                 hits_dropped;
      logic                 last_result;
   } trim_result_type;

   typedef struct packed {
      logic signed [ARC_W-1:0] arc;
      logic                    fin;
      logic                    typed;
      trim_result_type         want;
   } stim_row_type;

   localparam trim_result_type LONE_HIT = '{6'd0, 1'b0, 1'b0, 1'b1};
   localparam trim_result_type NO_WANT  = '{6'd0, 1'b0, 1'b0, 1'b0};

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [ARC_W-1:0] req_arc_length = '0;
   logic req_final_hit = 1'b0;
   logic rsp_valid;
   logic [HIT_NUM_W-1:0] rsp_hit_number;
   logic rsp_remove_hit;
   logic rsp_hits_dropped;
   logic rsp_last_result;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   hit_arc_gap_end_trimmer #(.MAX_HITS(HIT_CAP)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_arc_length(req_arc_length), .req_final_hit(req_final_hit),
      .rsp_valid(rsp_valid), .rsp_hit_number(rsp_hit_number),
      .rsp_remove_hit(rsp_remove_hit), .rsp_hits_dropped(rsp_hits_dropped),
      .rsp_last_result(rsp_last_result),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // trim predictor state
   logic [GAP_W-1:0]        gap_limit;
   logic signed [ARC_W-1:0] prev_arc;
   logic                    have_prev;
   logic [HIT_NUM_W-1:0]    seg_of_hit [HIT_CAP];
   logic [6:0]              seg_len [HIT_CAP];
   int                      hit_total;
   int                      seg_total;
   logic                    overflow_seen;

   trim_result_type trim_expect [$];
   int  bad_count = 0;
   int  cycle_count = 0;
   bit  steady = 0;

   stim_row_type directed_rows [26] = '{
      '{22'sd0,        1'b1, 1'b1, LONE_HIT},
      '{22'sd2097151,  1'b1, 1'b1, LONE_HIT},
      '{-22'sd2097152, 1'b1, 1'b1, LONE_HIT},
      '{-22'sd2097152, 1'b0, 1'b0, NO_WANT},
      '{-22'sd2094592, 1'b0, 1'b0, NO_WANT},
      '{22'sd0,        1'b0, 1'b0, NO_WANT},
      '{22'sd1,        1'b0, 1'b0, NO_WANT},
      '{22'sd2,        1'b0, 1'b0, NO_WANT},
      '{22'sd3,        1'b0, 1'b0, NO_WANT},
      '{22'sd4,        1'b0, 1'b0, NO_WANT},
      '{22'sd2565,     1'b1, 1'b0, NO_WANT},
      '{22'sd10,       1'b0, 1'b0, NO_WANT},
      '{22'sd5000,     1'b0, 1'b0, NO_WANT},
      '{22'sd10000,    1'b1, 1'b0, NO_WANT},
      '{22'sd100,      1'b0, 1'b0, NO_WANT},
      '{22'sd200,      1'b1, 1'b0, NO_WANT},
      '{-22'sd2097152, 1'b0, 1'b0, NO_WANT},
      '{22'sd2097151,  1'b0, 1'b0, NO_WANT},
      '{22'sd2097151,  1'b0, 1'b0, NO_WANT},
      '{22'sd2097151,  1'b0, 1'b0, NO_WANT},
      '{22'sd2097151,  1'b0, 1'b0, NO_WANT},
      '{22'sd2097151,  1'b0, 1'b0, NO_WANT},
      '{22'sd0,        1'b0, 1'b0, NO_WANT},
      '{22'sd0,        1'b0, 1'b0, NO_WANT},
      '{22'sd0,        1'b0, 1'b0, NO_WANT},
      '{22'sd0,        1'b1, 1'b0, NO_WANT}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_track();
      prev_arc = '0;
      have_prev = 1'b0;
      hit_total = 0;
      seg_total = 0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void trim_track(input logic signed [ARC_W-1:0] arc, input logic fin,
                                      input bit record);
      int step;
      bit split;
      int lo;
      int hi;
      trim_result_type r;
      if (hit_total >= HIT_CAP) begin
         overflow_seen = 1'b1;
      end else begin
         split = !have_prev;
         if (have_prev) begin
            step = int'(arc) - int'(prev_arc);
            if (step < 0) step = -step;
            if (step > int'(gap_limit)) split = 1;
         end
         if (split && seg_total < HIT_CAP) begin
            seg_len[seg_total] = '0;
            seg_total++;
         end
         seg_of_hit[hit_total] = HIT_NUM_W'(seg_total - 1);
         seg_len[seg_total - 1] = seg_len[seg_total - 1] + 7'd1;
         hit_total++;
         prev_arc = arc;
         have_prev = 1'b1;
      end
      if (fin) begin
         lo = 0;
         hi = seg_total;
         if (seg_total > 1) begin
            while (hi > lo && seg_len[hi - 1] <= SMALL_SEGMENT) hi--;
            while (lo < hi && seg_len[lo] <= SMALL_SEGMENT) lo++;
         end
         for (int k = 0; k < hit_total; k++) begin
            r.hit_number   = HIT_NUM_W'(k);
            r.remove_hit   = (seg_total > 1) && (seg_of_hit[k] < lo || seg_of_hit[k] >= hi);
            r.hits_dropped = overflow_seen;
            r.last_result  = (k + 1 == hit_total);
            if (record) trim_expect = {trim_expect, r};
         end
         clear_track();
      end
   endfunction

   function automatic int clamp_arc(input longint v);
      if (v < ARC_MIN) return ARC_MIN;
      if (v > ARC_MAX) return ARC_MAX;
      return int'(v);
   endfunction

   function automatic int draw_pause();
      if (steady) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic send_hit(input logic signed [ARC_W-1:0] arc, input logic fin,
                           input bit record);
      int pause;
      pause = draw_pause();
      if (pause > 0) begin
         start <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      start <= 1'b1;
      req_arc_length <= arc;
      req_final_hit <= fin;
      do @(posedge clock); while (busy);
      trim_track(arc, fin, record);
   endtask

   // one track of segments: small steps inside a segment, jumps beyond the gap between them, some random arcs
   task automatic send_track(input int g, input bit overflow, output int sent);
      int arcs [$];
      int arc_now;
      int n_seg;
      int seg_size;
      int target;
      longint jump;
      arc_now = int'($urandom_range(0, 4194303)) + ARC_MIN;
      n_seg = overflow ? 64 : $urandom_range(1, 3);
      target = overflow ? HIT_CAP + $urandom_range(1, 4) : 0;
      for (int s = 0; s < n_seg; s++) begin
         seg_size = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 8);
         for (int h = 0; h < seg_size; h++) begin
            if (s > 0 && h == 0) begin
               jump = longint'(g) + 1 + $urandom_range(0, 3000);
               arc_now = clamp_arc(arc_now >= 0 ? arc_now - jump : arc_now + jump);
            end else if (h > 0) begin
               arc_now = clamp_arc(longint'(arc_now) + longint'($urandom_range(0, 2 * g)) - g);
            end
            if ($urandom_range(0, 9) == 0)
               arcs = {arcs, int'($urandom_range(0, 4194303)) + ARC_MIN};
            else
               arcs = {arcs, arc_now};
         end
         if (overflow && arcs.size() >= target) break;
      end
      if (overflow && arcs.size() > target) arcs = arcs[0:target-1];
      foreach (arcs[i]) send_hit(ARC_W'(arcs[i]), i == arcs.size() - 1, 1'b1);
      sent = arcs.size();
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (trim_expect.size() != 0 || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_gap(input logic [GAP_W-1:0] g);
      logic [31:0] seen;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= GAP_ADDR;
      pwdata <= 32'(g);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      gap_limit = g;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (seen[GAP_W-1:0] !== g) begin
         $error("max_arc_gap: expected %0d, got %0d", g, seen[GAP_W-1:0]);
         bad_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      trim_result_type want;
      if (!reset && rsp_valid) begin
         if (trim_expect.size() == 0) begin
            $error("unexpected transaction: hit_number %0d", rsp_hit_number);
            bad_count++;
         end else begin
            want = trim_expect.pop_front();
            if (rsp_hit_number !== want.hit_number) begin
               $error("hit_number: expected %0d, got %0d", want.hit_number, rsp_hit_number);
               bad_count++;
            end
            if (rsp_remove_hit !== want.remove_hit) begin
               $error("remove_hit: expected %0d, got %0d", want.remove_hit, rsp_remove_hit);
               bad_count++;
            end
            if (rsp_hits_dropped !== want.hits_dropped) begin
               $error("hits_dropped: expected %0d, got %0d",
                      want.hits_dropped, rsp_hits_dropped);
               bad_count++;
            end
            if (rsp_last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d", want.last_result, rsp_last_result);
               bad_count++;
            end
         end
      end
   end

   initial begin
      int gaps [5];
      int sent;
      int phase_items;
      gap_limit = RESET_GAP;
      clear_track();
      foreach (seg_len[i]) begin
         seg_len[i] = '0;
         seg_of_hit[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_hit(directed_rows[i].arc, directed_rows[i].fin, !directed_rows[i].typed);
         if (directed_rows[i].typed) trim_expect = {trim_expect, directed_rows[i].want};
      end
      wait_drained();

      gaps = '{0, int'(GAP_TOP), int'(RESET_GAP), $urandom_range(1, 50000),
               $urandom_range(1, 4000)};
      foreach (gaps[p]) begin
         write_gap(GAP_W'(gaps[p]));
         steady = (p % 2 == 1);
         if (p == 2) begin
            send_track(gaps[p], 1'b1, sent);
         end else begin
            phase_items = 0;
            while (phase_items < 10) begin
               send_track(gaps[p], 1'b0, sent);
               phase_items += sent;
            end
         end
         wait_drained();
      end

      if (trim_expect.size() != 0) bad_count++;
      if (bad_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
